// ===== rtl/core/cmc_pkg.sv =====
// Package: widths, register indexes, class codes and divider interface types.
`default_nettype none
package cmc_pkg;

	localparam int unsigned NUM_MARKERS  = 3;
	localparam int unsigned CH_W         = 8;
	localparam int unsigned COLOR_W      = 3 * CH_W;
	localparam int unsigned TOL_W        = 8;
	localparam int unsigned COORD_W      = 10;
	localparam int unsigned SUM_W        = 30;
	localparam int unsigned CNT_W        = 21;
	localparam int unsigned CLS_W        = 2;
	localparam int unsigned ADDR_W       = 2;
	localparam int unsigned FRAME_WIDTH  = 1024;
	localparam int unsigned FRAME_HEIGHT = 1024;

	localparam int unsigned NUM_JOBS  = 2 * NUM_MARKERS;
	localparam int unsigned JOB_W     = $clog2(NUM_JOBS);
	localparam int unsigned DIV_STEPS = SUM_W;
	localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

	localparam logic [ADDR_W-1:0] REG_MARKER1 = 2'd0;
	localparam logic [ADDR_W-1:0] REG_MARKER2 = 2'd1;
	localparam logic [ADDR_W-1:0] REG_MARKER3 = 2'd2;
	localparam logic [ADDR_W-1:0] REG_TOL     = 2'd3;

	localparam logic [COLOR_W-1:0] MARKER1_RST = 24'hFF0000;
	localparam logic [COLOR_W-1:0] MARKER2_RST = 24'h00FF00;
	localparam logic [COLOR_W-1:0] MARKER3_RST = 24'h0000FF;
	localparam logic [TOL_W-1:0]   TOL_RST     = 8'd20;

	localparam logic [CLS_W-1:0] CLS_NONE = 2'd0;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [COORD_W-1:0] quot;
	} div_rsp_t;

	function automatic logic chan_close(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
		input logic [TOL_W-1:0] tol);
		logic [CH_W-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return d < tol;
	endfunction

	function automatic logic color_close(input logic [COLOR_W-1:0] ref_c,
		input logic [CH_W-1:0] r, input logic [CH_W-1:0] g, input logic [CH_W-1:0] b,
		input logic [TOL_W-1:0] tol);
		return chan_close(ref_c[3*CH_W-1:2*CH_W], r, tol)
			&& chan_close(ref_c[2*CH_W-1:CH_W], g, tol)
			&& chan_close(ref_c[CH_W-1:0], b, tol);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cmc_classify.sv =====
// Priority classifier of one pixel against the three marker colors.
`default_nettype none
module cmc_classify import cmc_pkg::*; (
	input  wire logic [NUM_MARKERS-1:0][COLOR_W-1:0] colors,
	input  wire logic [TOL_W-1:0]                    tol,
	input  wire logic [CH_W-1:0]                     r,
	input  wire logic [CH_W-1:0]                     g,
	input  wire logic [CH_W-1:0]                     b,
	input  wire logic                                in_frame,
	output logic      [CLS_W-1:0]                    cls
);

	always_comb begin
		cls = CLS_NONE;
		if (in_frame) begin
			for (int k = NUM_MARKERS - 1; k >= 0; k--) begin
				if (color_close(colors[k], r, g, b, tol)) begin
					cls = CLS_W'(k + 1);
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/cmc_divider.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module cmc_divider import cmc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W-1:0]  diff;
	logic              ge;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial[CNT_W-1:0] - dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q[COORD_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/color_marker_centroid.sv =====
// Top level: color marker classifier with per-frame centroid computation.
// Usage:
//   Pixels enter on the in_valid/in_ready channel with column, row and last_pixel.
//   Every pixel gives exactly one transaction on out_valid/out_ready: its marker
//   class, and on the frame's last pixel also frame_done and the three centroids.
//   An ordinary pixel is classified and accumulated in the cycle it is accepted;
//   its result shows the next cycle, so one pixel per cycle flows while the
//   receiver keeps out_ready high.
//   The last pixel of a frame starts six divisions (x and y per marker) on one
//   shared bit-serial divider of 30 steps, launched one after another; the
//   frame result appears after the last of them is done.
//   in_ready is low until then.
//   A result held by a stalled receiver stays in the output register; a new
//   pixel is accepted only in the cycle that register is free or being taken.
//   Reset restores the marker colors and tolerance, clears all sums and counts
//   and empties the output register. Configuration writes take effect at once
//   and must happen only while the block is idle.
`default_nettype none
module color_marker_centroid import cmc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [ADDR_W-1:0]  cfg_addr,
	input  wire logic [COLOR_W-1:0] cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [CH_W-1:0]    pixel_red,
	input  wire logic [CH_W-1:0]    pixel_green,
	input  wire logic [CH_W-1:0]    pixel_blue,
	input  wire logic [COORD_W-1:0] column,
	input  wire logic [COORD_W-1:0] row,
	input  wire logic               last_pixel,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [CLS_W-1:0]        marker_class,
	output logic                    frame_done,
	output logic                    first_found,
	output logic [COORD_W-1:0]      first_x,
	output logic [COORD_W-1:0]      first_y,
	output logic                    second_found,
	output logic [COORD_W-1:0]      second_x,
	output logic [COORD_W-1:0]      second_y,
	output logic                    third_found,
	output logic [COORD_W-1:0]      third_x,
	output logic [COORD_W-1:0]      third_y
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_LAUNCH = 3'b010,
		ST_WAIT   = 3'b100
	} state_t;

	localparam logic [JOB_W-1:0] JOB_LAST = JOB_W'(NUM_JOBS - 1);

	state_t st_q;
	logic [JOB_W-1:0] jb_q;

	logic [NUM_MARKERS-1:0][COLOR_W-1:0] color_q;
	logic [TOL_W-1:0] tol_q;

	logic [SUM_W-1:0] col_sum_q [NUM_MARKERS];
	logic [SUM_W-1:0] row_sum_q [NUM_MARKERS];
	logic [CNT_W-1:0] cnt_q     [NUM_MARKERS];

	logic [COORD_W-1:0] res_q [NUM_JOBS];

	logic               out_valid_q;
	logic [CLS_W-1:0]   cls_q;
	logic               done_q;
	logic [NUM_MARKERS-1:0] found_q;
	logic [COORD_W-1:0] x_q [NUM_MARKERS];
	logic [COORD_W-1:0] y_q [NUM_MARKERS];

	logic             in_frame;
	logic [CLS_W-1:0] cls;
	logic             in_acc;
	logic             out_acc;
	logic             finish;
	div_req_t         div_req;
	div_rsp_t         div_rsp;

	assign in_frame = (32'(column) < FRAME_WIDTH) && (32'(row) < FRAME_HEIGHT);
	assign in_ready = (st_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid_q && out_ready;
	assign finish   = (st_q == ST_WAIT) && div_rsp.done && (jb_q == JOB_LAST);

	cmc_classify u_classify (
		.colors   (color_q),
		.tol      (tol_q),
		.r        (pixel_red),
		.g        (pixel_green),
		.b        (pixel_blue),
		.in_frame (in_frame),
		.cls      (cls)
	);

	assign div_req.start    = (st_q == ST_LAUNCH);
	assign div_req.dividend = jb_q[0] ? row_sum_q[jb_q[JOB_W-1:1]] : col_sum_q[jb_q[JOB_W-1:1]];
	assign div_req.divisor  = cnt_q[jb_q[JOB_W-1:1]];

	cmc_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q[0] <= MARKER1_RST;
			color_q[1] <= MARKER2_RST;
			color_q[2] <= MARKER3_RST;
			tol_q      <= TOL_RST;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_MARKER1: color_q[0] <= cfg_wdata;
				REG_MARKER2: color_q[1] <= cfg_wdata;
				REG_MARKER3: color_q[2] <= cfg_wdata;
				REG_TOL:     tol_q      <= cfg_wdata[TOL_W-1:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_MARKERS; k++) begin
				col_sum_q[k] <= '0;
				row_sum_q[k] <= '0;
				cnt_q[k]     <= '0;
			end
		end else if (finish) begin
			for (int k = 0; k < NUM_MARKERS; k++) begin
				col_sum_q[k] <= '0;
				row_sum_q[k] <= '0;
				cnt_q[k]     <= '0;
			end
		end else if (in_acc) begin
			for (int k = 0; k < NUM_MARKERS; k++) begin
				if (cls == CLS_W'(k + 1)) begin
					col_sum_q[k] <= col_sum_q[k] + SUM_W'(column);
					row_sum_q[k] <= row_sum_q[k] + SUM_W'(row);
					cnt_q[k]     <= cnt_q[k] + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			jb_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (in_acc && last_pixel) begin
						st_q <= ST_LAUNCH;
						jb_q <= '0;
					end
				end
				ST_LAUNCH: st_q <= ST_WAIT;
				ST_WAIT: begin
					if (div_rsp.done) begin
						if (jb_q == JOB_LAST) begin
							st_q <= ST_IDLE;
						end else begin
							st_q <= ST_LAUNCH;
							jb_q <= jb_q + 1'b1;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_WAIT && div_rsp.done) begin
			res_q[jb_q] <= div_rsp.quot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish || (in_acc && !last_pixel)) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cls_q   <= cls;
			done_q  <= 1'b0;
			found_q <= '0;
			for (int k = 0; k < NUM_MARKERS; k++) begin
				x_q[k] <= '0;
				y_q[k] <= '0;
			end
		end else if (finish) begin
			done_q <= 1'b1;
			for (int k = 0; k < NUM_MARKERS; k++) begin
				found_q[k] <= (cnt_q[k] != '0);
				if (k == NUM_MARKERS - 1) begin
					x_q[k] <= (cnt_q[k] != '0) ? res_q[2 * k] : '0;
					y_q[k] <= (cnt_q[k] != '0) ? div_rsp.quot : '0;
				end else begin
					x_q[k] <= (cnt_q[k] != '0) ? res_q[2 * k] : '0;
					y_q[k] <= (cnt_q[k] != '0) ? res_q[2 * k + 1] : '0;
				end
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign marker_class = cls_q;
	assign frame_done   = done_q;
	assign first_found  = found_q[0];
	assign first_x      = x_q[0];
	assign first_y      = y_q[0];
	assign second_found = found_q[1];
	assign second_x     = x_q[1];
	assign second_y     = y_q[1];
	assign third_found  = found_q[2];
	assign third_x      = x_q[2];
	assign third_y      = y_q[2];

`ifndef SYNTHESIS
	a_last_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && last_pixel) |=> (st_q == ST_LAUNCH && !out_valid))
		else $error("last pixel did not start centroid divisions");

	a_finish_result: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (st_q == ST_IDLE && out_valid && frame_done && cnt_q[0] == '0
			&& cnt_q[1] == '0 && cnt_q[2] == '0))
		else $error("frame result or accumulator clear missing");

	a_no_found_midframe: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !frame_done) |-> !(first_found || second_found || third_found))
		else $error("found flag outside frame end");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !second_found) |-> (second_x == '0 && second_y == '0))
		else $error("centroid nonzero for absent marker");
`endif

endmodule
`default_nettype wire
